// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/crc5sec_pkg.sv -----
// ----------------------------------------------------------------------------
// crc5sec_pkg
// Types, constants and tables of the crc5 single error corrector
// (generator x^5 + x^2 + 1).
// ----------------------------------------------------------------------------
`default_nettype none

package crc5sec_pkg;

	localparam int CW_MAX  = 31;                 // longest codeword
	localparam int CHK_LEN = 5;                  // check bits
	localparam int MSG_MAX = CW_MAX - CHK_LEN;   // longest message

	// request codes
	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	// status codes
	localparam logic [1:0] ST_CLEAN     = 2'd0;
	localparam logic [1:0] ST_CORRECTED = 2'd1;
	localparam logic [1:0] ST_UNCORR    = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [CW_MAX-1:0] word_in;
	} req_t;

	typedef struct packed {
		logic [CW_MAX-1:0]  word_out;
		logic [CHK_LEN-1:0] check_bits;
		logic [1:0]         status;
		logic [4:0]         error_position;
	} rsp_t;

	// x^i mod g for every bit position of the codeword
	localparam logic [CHK_LEN-1:0] POW_TBL [0:CW_MAX-1] = '{
		5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd5,  5'd10, 5'd20,
		5'd13, 5'd26, 5'd17, 5'd7,  5'd14, 5'd28, 5'd29, 5'd31,
		5'd27, 5'd19, 5'd3,  5'd6,  5'd12, 5'd24, 5'd21, 5'd15,
		5'd30, 5'd25, 5'd23, 5'd11, 5'd22, 5'd9,  5'd18
	};

	// inverse of POW_TBL: syndrome to bit position (g is primitive)
	function automatic logic [4:0] syn_pos(input logic [CHK_LEN-1:0] s);
		logic [4:0] p;
		case (s)
			5'd1:    p = 5'd0;
			5'd2:    p = 5'd1;
			5'd4:    p = 5'd2;
			5'd8:    p = 5'd3;
			5'd16:   p = 5'd4;
			5'd5:    p = 5'd5;
			5'd10:   p = 5'd6;
			5'd20:   p = 5'd7;
			5'd13:   p = 5'd8;
			5'd26:   p = 5'd9;
			5'd17:   p = 5'd10;
			5'd7:    p = 5'd11;
			5'd14:   p = 5'd12;
			5'd28:   p = 5'd13;
			5'd29:   p = 5'd14;
			5'd31:   p = 5'd15;
			5'd27:   p = 5'd16;
			5'd19:   p = 5'd17;
			5'd3:    p = 5'd18;
			5'd6:    p = 5'd19;
			5'd12:   p = 5'd20;
			5'd24:   p = 5'd21;
			5'd21:   p = 5'd22;
			5'd15:   p = 5'd23;
			5'd30:   p = 5'd24;
			5'd25:   p = 5'd25;
			5'd23:   p = 5'd26;
			5'd11:   p = 5'd27;
			5'd22:   p = 5'd28;
			5'd9:    p = 5'd29;
			5'd18:   p = 5'd30;
			default: p = 5'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/crc5_single_error_corrector_top.sv -----
// ----------------------------------------------------------------------------
// crc5_single_error_corrector_top
// Encoder and single error corrector for the shortened cyclic code with
// generator x^5 + x^2 + 1, three register stages.
//
//   channel   signals                          handshake
//   request   start, busy, req                 start & !busy
//   result    done, result                     done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid & cfg_ready
//
// One beat enters every cycle. Stage 1 masks the word to the message or
// codeword length, stage 2 runs the syndrome xor tree, stage 3 locates
// and flips the bit. busy stays low since the result side never stalls.
// Reset clears the stage valid bits and loads a message length of 26.
// ----------------------------------------------------------------------------
`default_nettype none

module crc5_single_error_corrector_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire crc5sec_pkg::req_t    req,
	output logic                      done,
	output crc5sec_pkg::rsp_t         result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [4:0]           cfg_data
);
	import crc5sec_pkg::*;

	logic [4:0]         msg_bits_q;
	logic [4:0]         eff_k;
	logic [4:0]         code_len;
	logic [CW_MAX-1:0]  mask_k;
	logic [CW_MAX-1:0]  mask_n;
	logic [CW_MAX-1:0]  word_m;

	logic               vld_s1, vld_s2, vld_s3;
	logic               typ_s1, typ_s2;
	logic [CW_MAX-1:0]  word_s1, word_s2;
	logic [4:0]         len_s1, len_s2;
	logic [CHK_LEN-1:0] syn_c, syn_s2;
	rsp_t               rsp_c, rsp_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_bits_q <= 5'(MSG_MAX);
		end else if (cfg_valid && cfg_ready) begin
			msg_bits_q <= cfg_data;
		end
	end

	// effective lengths and masks
	assign eff_k    = (msg_bits_q > 5'(MSG_MAX)) ? 5'(MSG_MAX) : msg_bits_q;
	assign code_len = eff_k + 5'(CHK_LEN);
	assign mask_k   = {CW_MAX{1'b1}} >> (5'(CW_MAX) - eff_k);
	assign mask_n   = {CW_MAX{1'b1}} >> (5'(CW_MAX) - code_len);

	// encode shifts the message up; decode keeps the codeword bits
	assign word_m = (req.req_type == REQ_ENCODE)
		? ((req.word_in & mask_k) << CHK_LEN)
		: (req.word_in & mask_n);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: masked word
	always_ff @(posedge clk) begin
		typ_s1  <= req.req_type;
		word_s1 <= word_m;
		len_s1  <= code_len;
	end

	// syndrome xor tree, also the encode remainder
	always_comb begin
		syn_c = '0;
		for (int i = 0; i < CW_MAX; i++) begin
			if (word_s1[i]) begin
				syn_c = syn_c ^ POW_TBL[i];
			end
		end
	end

	// stage 2: syndrome
	always_ff @(posedge clk) begin
		typ_s2  <= typ_s1;
		word_s2 <= word_s1;
		len_s2  <= len_s1;
		syn_s2  <= syn_c;
	end

	crc5sec_fix u_fix (
		.req_type (typ_s2),
		.word     (word_s2),
		.syn      (syn_s2),
		.code_len (len_s2),
		.rsp      (rsp_c)
	);

	// stage 3: result beat
	always_ff @(posedge clk) begin
		rsp_s3 <= rsp_c;
	end

	assign done   = vld_s3;
	assign result = rsp_s3;

endmodule

`default_nettype wire

// ----- hdl/crc5sec_fix.sv -----
// ----------------------------------------------------------------------------
// crc5sec_fix
// Last stage logic: decode maps the syndrome to a bit position, flips it
// when inside the codeword; encode ORs in check bits. Forms the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module crc5sec_fix (
	input  wire logic                               req_type,
	input  wire logic [crc5sec_pkg::CW_MAX-1:0]     word,
	input  wire logic [crc5sec_pkg::CHK_LEN-1:0]    syn,
	input  wire logic [4:0]                         code_len,
	output crc5sec_pkg::rsp_t                       rsp
);
	import crc5sec_pkg::*;

	logic [4:0]        pos;
	logic              in_word;
	logic [CW_MAX-1:0] flip;

	// candidate error position and its one-hot flip mask
	assign pos     = syn_pos(syn);
	assign in_word = (pos < code_len);
	assign flip    = CW_MAX'(1) << pos;

	// result beat
	always_comb begin
		rsp.check_bits     = syn;
		rsp.status         = ST_CLEAN;
		rsp.error_position = 5'd0;
		if (req_type == REQ_ENCODE) begin
			rsp.word_out = word | CW_MAX'(syn);
		end else begin
			rsp.word_out = word;
			if (syn != '0) begin
				if (in_word) begin
					rsp.word_out       = word ^ flip;
					rsp.status         = ST_CORRECTED;
					rsp.error_position = pos;
				end else begin
					rsp.status = ST_UNCORR;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/crc5sec_checker.sv -----
// ----------------------------------------------------------------------------
// crc5sec_checker
// Port level checks of the crc5 single error corrector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crc5sec_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire crc5sec_pkg::req_t  req,
	input  wire logic               done,
	input  wire crc5sec_pkg::rsp_t  result
);
	import crc5sec_pkg::*;

	logic accept;
	logic is_enc;
	logic st_corr;
	logic legal_st;

	// handshake and status shorthands
	assign accept   = start && !busy;
	assign is_enc   = (req.req_type == REQ_ENCODE);
	assign st_corr  = (result.status == ST_CORRECTED);
	assign legal_st = (result.status == ST_CLEAN) || ((result.check_bits != '0) &&
		((result.status == ST_CORRECTED) || (result.status == ST_UNCORR)));

	// every result beat comes from an earlier accepted request
	`ASSERT_IMPLIES(a_latency, clk, arst_n, done, $past(accept, 3))

	// encode results are always clean
	`ASSERT_IMPLIES(a_enc_clean, clk, arst_n, done && $past(is_enc, 3), result.status == ST_CLEAN)

	// a position is reported only for a corrected word
	`ASSERT_IMPLIES(a_pos_zero, clk, arst_n, done && !st_corr, result.error_position == 5'd0)

	// a correction or an uncorrectable word needs a nonzero syndrome, a legal status always
	`ASSERT_IMPLIES(a_status, clk, arst_n, done, legal_st)

	// every accepted request gets its result beat
	`ASSERT_IMPLIES(a_follow, clk, arst_n, $past(accept, 3), done)

endmodule

bind crc5_single_error_corrector_top crc5sec_checker u_crc5sec_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);

`default_nettype wire
